// File: rtl/ttw_pkg.sv
// ============================================================================
// ttw_pkg - text terminal writer package
// Shared constants, state and command codes, and the queue entry format.
// ============================================================================
package ttw_pkg;

  // Default screen geometry and the geometry that sizes the address fields
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;
  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned MAX_ROWS    = 128;
  localparam int unsigned AW_MAX      = $clog2(MAX_COLUMNS * MAX_ROWS);

  // Character and attribute codes
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  RESET_COLOR  = 8'd7;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};
  localparam logic [7:0]  FILL_CHAR    = 8'd0;

  // Input operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Entries between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Work for the back end
  typedef enum logic [1:0] {
    CMD_PUT,   // write one cell
    CMD_READ,  // read one cell
    CMD_NONE   // no cell access (newline, read off screen)
  } cmd_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    ST_INIT,   // reset sweep over the screen
    ST_IDLE,   // take next command
    ST_READ,   // cell read data arrives
    ST_FILL    // blank the new bottom row
  } st_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [AW_MAX-1:0] addr;       // cell address for put or read
    logic [15:0]       cell_data;  // cell to write, zero otherwise
    logic              scroll;     // item scrolled the screen
    logic [AW_MAX-1:0] fill_base;  // first cell of the row to blank
    logic [7:0]        fill_attr;  // attribute of the blank row
    logic [4:0]        cur_row;    // cursor after the item
    logic [6:0]        cur_col;
  } item_t;

endpackage

// File: rtl/ttw_front.sv
// ============================================================================
// ttw_front - input side of the text terminal writer
// Accepts items, tracks the cursor and the scroll offset, and turns each
// item into one command with a resolved cell address.
// ============================================================================
module ttw_front import ttw_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_byte, read_row, read_col, zero pad
  input  logic [0:0]  s_axis_tuser,   // operation
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // text_color
  input  logic        init_done_i,
  input  logic        q_ready_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned AW = $clog2(ROWS * COLUMNS);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] base_q, base_d;
  logic [7:0]    color_q;

  logic          op;
  logic [7:0]    ch;
  logic [4:0]    rd_row;
  logic [6:0]    rd_col;
  logic          is_nl;
  logic [CW:0]   col_inc;
  logic          wrap;
  logic          last_row;
  logic          scroll;
  logic          in_range;
  logic [31:0]   rd_row32;
  logic [31:0]   rd_col32;
  logic [RW-1:0] put_prow;
  logic [RW-1:0] rd_prow;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] fill_base;

  // Map a screen row onto its storage row through the scroll offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] base);
    logic [RW:0] sum;
    sum = {1'b0, lr} + {1'b0, base};
    if (32'(sum) >= ROWS) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  // Unpack the input transfer
  assign op       = s_axis_tuser[0];
  assign ch       = s_axis_tdata[7:0];
  assign rd_row   = s_axis_tdata[12:8];
  assign rd_col   = s_axis_tdata[19:13];
  assign rd_row32 = 32'(rd_row);
  assign rd_col32 = 32'(rd_col);

  // Classify and advance the cursor
  assign is_nl     = (ch == NEWLINE_CODE);
  assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
  assign wrap      = is_nl || (col_inc == (CW+1)'(COLUMNS));
  assign last_row  = (row_q == RW'(ROWS - 1));
  assign scroll    = (op == OP_PUT) && wrap && last_row;
  assign in_range  = (rd_row32 < ROWS) && (rd_col32 < COLUMNS);

  assign put_prow  = phys_row(row_q, base_q);
  assign rd_prow   = phys_row(rd_row32[RW-1:0], base_q);
  assign put_addr  = AW'(32'(put_prow) * COLUMNS + 32'(col_q));
  assign rd_addr   = AW'(32'(rd_prow) * COLUMNS + rd_col32);
  // The old top row becomes the new bottom row
  assign fill_base = AW'(32'(base_q) * COLUMNS);

  assign s_axis_tready = q_ready_i && init_done_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Build the command and next cursor
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    base_d = base_q;
    q_item_o           = '0;
    q_item_o.fill_base = AW_MAX'(fill_base);
    q_item_o.fill_attr = color_q;
    q_item_o.scroll    = scroll;
    if (op == OP_PUT) begin
      q_item_o.cmd       = is_nl ? CMD_NONE : CMD_PUT;
      q_item_o.addr      = AW_MAX'(put_addr);
      q_item_o.cell_data = is_nl ? 16'h0000 : {color_q, ch};
      if (wrap) begin
        col_d = '0;
        if (last_row) begin
          base_d = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end else begin
      q_item_o.cmd  = in_range ? CMD_READ : CMD_NONE;
      q_item_o.addr = AW_MAX'(rd_addr);
    end
    q_item_o.cur_row = 5'(row_d);
    q_item_o.cur_col = 7'(col_d);
  end

  // Cursor and scroll offset advance on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      base_q <= '0;
    end else if (q_push_o) begin
      row_q  <= row_d;
      col_q  <= col_d;
      base_q <= base_d;
    end
  end

  // Text color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= RESET_COLOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS) else $error("cursor row off screen");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS) else $error("cursor column off screen");
  a_no_early_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> init_done_i) else $error("transfer during screen clear");

endmodule

// File: rtl/ttw_queue.sv
// ============================================================================
// ttw_queue - command queue
// Short in-order queue that decouples the front from the back end.
// ============================================================================
module ttw_queue import ttw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  item_t         entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign ready_o = (count_q != (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/ttw_back.sv
// ============================================================================
// ttw_back - screen memory and command execution
// Holds the cell memory, clears it after reset, executes queued commands,
// blanks the bottom row on scroll and drives the output register.
// ============================================================================
module ttw_back import ttw_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        init_done_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cell_char, cell_attr, cursor_row_out,
                                     // cursor_col_out, scrolled, zero pad
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_q;

  st_e           st_q, st_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] fbase_q, fbase_d;
  logic [7:0]    fattr_q, fattr_d;
  logic [4:0]    hrow_q, hrow_d;
  logic [6:0]    hcol_q, hcol_d;

  logic          we, re;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          out_free;
  logic [7:0]    o_char_d, o_char_q;
  logic [7:0]    o_attr_d, o_attr_q;
  logic [4:0]    o_row_d, o_row_q;
  logic [6:0]    o_col_d, o_col_q;
  logic          o_scr_d, o_scr_q;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign q_pop_o     = (st_q == ST_IDLE) && q_valid_i && out_free;
  assign init_done_o = (st_q != ST_INIT);

  // Cell memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Sequencer: next state, memory access and output load
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    fbase_d  = fbase_q;
    fattr_d  = fattr_q;
    hrow_d   = hrow_q;
    hcol_d   = hcol_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = cnt_q;
    wdata    = RESET_CELL;
    raddr    = q_item_i.addr[AW-1:0];
    out_load = 1'b0;
    o_char_d = '0;
    o_attr_d = '0;
    o_row_d  = q_item_i.cur_row;
    o_col_d  = q_item_i.cur_col;
    o_scr_d  = q_item_i.scroll;
    unique case (st_q)
      ST_INIT: begin
        we    = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop_o) begin
          unique case (q_item_i.cmd)
            CMD_PUT: begin
              we       = 1'b1;
              waddr    = q_item_i.addr[AW-1:0];
              wdata    = q_item_i.cell_data;
              out_load = 1'b1;
            end
            CMD_READ: begin
              re     = 1'b1;
              hrow_d = q_item_i.cur_row;
              hcol_d = q_item_i.cur_col;
              st_d   = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          if (q_item_i.scroll) begin
            cnt_d   = '0;
            fbase_d = q_item_i.fill_base[AW-1:0];
            fattr_d = q_item_i.fill_attr;
            st_d    = ST_FILL;
          end
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        o_char_d = rdata_q[7:0];
        o_attr_d = rdata_q[15:8];
        o_row_d  = hrow_q;
        o_col_d  = hcol_q;
        o_scr_d  = 1'b0;
        st_d     = ST_IDLE;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = fbase_q + cnt_q;
        wdata = {fattr_q, FILL_CHAR};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(COLUMNS - 1)) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Hold a result until the output transfer
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fbase_q <= fbase_d;
    fattr_q <= fattr_d;
    hrow_q  <= hrow_d;
    hcol_q  <= hcol_d;
    if (out_load) begin
      o_char_q <= o_char_d;
      o_attr_q <= o_attr_d;
      o_row_q  <= o_row_d;
      o_col_q  <= o_col_d;
      o_scr_q  <= o_scr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, o_scr_q, o_col_q, o_row_q, o_attr_q, o_char_q};

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ) |-> !out_valid_q) else $error("read result would overwrite");
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.cmd == CMD_READ) |=> (st_q == ST_READ))
    else $error("read did not enter data phase");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> (32'(cnt_q) < COLUMNS)) else $error("row fill overran");

endmodule

// File: rtl/text_terminal_writer.sv
// ============================================================================
// text_terminal_writer - character-cell text terminal
//
//   channel   dir  handshake                      carries
//   s_axis    in   s_axis_tvalid/s_axis_tready    put or read item
//   m_axis    out  m_axis_tvalid/m_axis_tready    cell and cursor result
//   cfg       in   cfg_valid_i/cfg_ready_o        text color attribute
//
// A read passes through a registered memory read. A scroll also blanks the
// new bottom row in cell memory. After reset the whole cell memory is swept
// before the first input transfer; cfg is taken throughout.
// A four-entry queue lets the front keep accepting while the back end works
// or the output waits; the output register holds one result.
// ============================================================================
module text_terminal_writer import ttw_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_byte, read_row, read_col, zero pad
  input  logic [0:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cell_char, cell_attr, cursor_row_out,
                                      // cursor_col_out, scrolled, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i      // text_color
);

  logic  init_done;
  logic  q_ready;
  logic  q_push;
  item_t q_in_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_out_item;

  // Accept and classify
  ttw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .init_done_i   (init_done),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item)
  );

  // Decouple front and back
  ttw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  // Execute against cell memory
  ttw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_out_item),
    .q_pop_o       (q_pop),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: dv/text_terminal_writer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// text_terminal_writer_tb - self-checking bench for the text terminal writer
// Streams put and read transfers into the terminal, predicts every report
// (cell, cursor, scroll flag) from a shadow copy of the screen and compares
// each output transfer field by field. It covers reset contents, off-screen
// reads, newline, row wrap, scroll with bottom-row fill and several text
// colors, under random sender gaps and receiver stalls.
// ============================================================================
module text_terminal_writer_tb;
  import ttw_pkg::*;

  localparam int unsigned COLS       = DEF_COLUMNS;
  localparam int unsigned ROWS       = DEF_ROWS;
  localparam int unsigned SETTLE_CYC = COLS + 40;   // scroll fill plus queue drain
  localparam int unsigned WDOG_LIMIT = 40000;       // idle cycles, covers the reset sweep
  localparam int unsigned RANDOM_ITEMS = 1050;

  // One output report, last member in the lowest bits as on tdata
  typedef struct packed {
    logic       scrolled;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
  } term_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // char_byte, read_row, read_col, zero pad
  logic [0:0]  s_axis_tuser = '0;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cell_char, cell_attr, cursor_row_out,
                                    // cursor_col_out, scrolled, zero pad
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;     // text_color

  text_terminal_writer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow terminal state
  logic [15:0]  shadow_screen [ROWS*COLS];
  int unsigned  shadow_row;
  int unsigned  shadow_col;
  logic [7:0]   shadow_color;

  term_report_t expected_reports [$];
  int unsigned  mismatch_count = 0;
  int unsigned  error_count    = 0;

  // Sender burst control
  int unsigned  burst_left = 0;
  bit           sender_steady = 1'b0;

  // Reset the shadow screen to grey spaces
  function automatic void shadow_reset();
    for (int i = 0; i < ROWS*COLS; i++) shadow_screen[i] = RESET_CELL;
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = RESET_COLOR;
  endfunction

  // Apply one item to the shadow terminal and return its report
  function automatic term_report_t terminal_step(logic op, logic [7:0] ch,
                                                 logic [4:0] rr, logic [6:0] rc);
    term_report_t rep;
    logic [15:0]  rd_cell;
    rep = '0;
    if (op == OP_READ) begin
      if (rr < ROWS && rc < COLS) begin
        rd_cell = shadow_screen[rr*COLS + rc];
        rep.cell_char = rd_cell[7:0];
        rep.cell_attr = rd_cell[15:8];
      end
    end else begin
      if (ch != NEWLINE_CODE) shadow_screen[shadow_row*COLS + shadow_col] = {shadow_color, ch};
      shadow_col++;
      if (ch == NEWLINE_CODE || shadow_col >= COLS) begin
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
          // shift rows up and blank the bottom one
          for (int i = 0; i < (ROWS-1)*COLS; i++) shadow_screen[i] = shadow_screen[i+COLS];
          for (int c = 0; c < COLS; c++)
            shadow_screen[(ROWS-1)*COLS + c] = {shadow_color, FILL_CHAR};
          shadow_row   = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
    end
    rep.cur_row = shadow_row[4:0];
    rep.cur_col = shadow_col[6:0];
    return rep;
  endfunction

  // Send one item; entered and left just after a rising edge
  task automatic send_item(logic op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rc, rr, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(terminal_step(op, ch, rr, rc));
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(OP_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
    send_item(OP_READ, 8'($urandom), rr, rc);
  endtask

  // Drain every report, let a scroll fill finish, then write the color
  task automatic set_color(logic [7:0] color);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= color;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_color = color;
    cfg_valid_i <= 1'b0;
  endtask

  // Count a failure, print the first few
  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h actual %0h", what, want, got);
  endfunction

  // Check output transfers, pace the receiver and watch for a hang
  int unsigned rx_period = 4;
  int unsigned rx_hold   = 0;
  int unsigned rx_phase  = 0;
  int unsigned rx_cycles = 0;
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : report_check
    term_report_t got;
    term_report_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[28:0];
      if (expected_reports.size() == 0) begin
        note_mismatch("unexpected report", 0, 32'(got));
      end else begin
        want = expected_reports.pop_front();
        if (got.cell_char != want.cell_char)
          note_mismatch("cell_char", 32'(want.cell_char), 32'(got.cell_char));
        if (got.cell_attr != want.cell_attr)
          note_mismatch("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
        if (got.cur_row != want.cur_row)
          note_mismatch("cursor_row", 32'(want.cur_row), 32'(got.cur_row));
        if (got.cur_col != want.cur_col)
          note_mismatch("cursor_col", 32'(want.cur_col), 32'(got.cur_col));
        if (got.scrolled != want.scrolled)
          note_mismatch("scrolled", 32'(want.scrolled), 32'(got.scrolled));
      end
    end

    // stall pattern: ready is low in the phases below rx_hold of each rx_period
    rx_cycles++;
    if (rx_cycles % 200 == 0) begin
      rx_period = $urandom_range(1, 16);
      rx_hold   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, rx_period);
    end
    rx_phase = (rx_phase + 1) % rx_period;
    m_axis_tready <= (rx_phase >= rx_hold);

    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("text_terminal_writer_tb: errors");
      $finish;
    end
  end

  // Reset contents, off-screen reads and puts in the reset color
  task automatic test_reset_state();
    read_cell(5'd0, 7'd0);
    read_cell(5'd24, 7'd79);
    read_cell(5'd17, 7'd64);
    read_cell(5'd25, 7'd0);
    read_cell(5'd0, 7'd80);
    read_cell(5'd31, 7'd127);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(SPACE_CODE);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    put_char(NEWLINE_CODE);
    read_cell(5'd0, 7'd3);
  endtask

  // New color applies to later puts only
  task automatic test_color_write();
    set_color(8'h1F);
    put_char(8'hAA);
    put_char(8'h55);
    read_cell(5'd1, 7'd0);
    read_cell(5'd0, 7'd0);
  endtask

  // Walk down with newlines and scroll off the bottom
  task automatic test_scroll();
    while (shadow_row < ROWS - 1) put_char(NEWLINE_CODE);
    put_char(8'h7E);
    put_char(NEWLINE_CODE);
    read_cell(5'd24, 7'd0);
    read_cell(5'd23, 7'd0);
    read_cell(5'd0, 7'd0);
  endtask

  // Random mix, mostly line-shaped text with reads near the cursor
  task automatic test_random();
    logic [7:0]  colors [7] = '{8'h00, 8'hFF, 8'h70, 8'h0F, 8'hF0, 8'h4E, 8'h00};
    int unsigned chunk = 150;
    int unsigned nl_pct;
    logic [4:0]  rr;
    logic [6:0]  rc;
    logic [7:0]  ch;
    for (int k = 0; k < 7; k++) begin
      if (k == 6) colors[k] = 8'($urandom);
      set_color(colors[k]);
      sender_steady = (k % 3 == 2);
      // odd chunks run long lines so the cursor wraps and scrolls by wrap
      nl_pct = (k % 2 == 1) ? 1 : 12;
      for (int i = 0; i < RANDOM_ITEMS / 7; i++) begin
        if ($urandom_range(0, 99) < 65) begin
          if ($urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
          else ch = 8'($urandom);
          put_char(ch);
        end else begin
          if ($urandom_range(0, 99) < 40) rr = 5'(shadow_row);
          else if ($urandom_range(0, 9) == 0) rr = 5'($urandom_range(ROWS, 31));
          else rr = 5'($urandom_range(0, ROWS - 1));
          if ($urandom_range(0, 9) == 0) rc = 7'($urandom_range(COLS, 127));
          else rc = 7'($urandom_range(0, COLS - 1));
          read_cell(rr, rc);
        end
      end
    end
    if (chunk == 0) burst_left = 0;
  endtask

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_color_write();
    test_scroll();
    test_random();

    // drain and let the block settle
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_reports.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("text_terminal_writer_tb: clean");
    end else begin
      $display("text_terminal_writer_tb: errors");
    end
    $finish;
  end

endmodule
